// ----- rtl/core/dipmd_pkg.sv -----
// Package for the dual incremental PI motor drive.
// Field widths, register codes, reset values and the pipeline control struct.
// No dependencies.
package dipmd_pkg;

    // accumulator default width and fraction bits
    localparam int ACCUM_BITS_DEF = 32;
    localparam int FRAC_BITS      = 8;

    // field widths
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // gain * error change plus gain * error, signed
    localparam int PROD_P_W = GAIN_W + 1 + DIFF_W;
    localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
    localparam int INC_W    = PROD_P_W;

    // register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 16'd7680;
    localparam logic [GAIN_W-1:0]  INTEGRAL_GAIN_RST = 16'd2560;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST   = 15'd7100;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 2'd0,
        REG_INTEGRAL_GAIN = 2'd1,
        REG_DRIVE_LIMIT   = 2'd2
    } cfg_reg_t;

    // stage load strobes from control to each wheel lane
    typedef struct packed {
        logic s1_load;   // error and error change
        logic s2_load;   // PI increment
        logic s3_load;   // accumulator update
        logic s4_load;   // drive value to result
    } pipe_ctl_t;

endpackage

// ----- rtl/core/dipmd_ctrl.sv -----
// Pipeline flow control for the dual incremental PI motor drive.
// Four stage valid bits with a ready chain; depends on dipmd_pkg.
module dipmd_ctrl
    import dipmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // a stage can take a beat when empty or when it hands its own beat on
    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctl.s1_load = in_valid && rdy1;
    assign ctl.s2_load = v1_reg && rdy2;
    assign ctl.s3_load = v2_reg && rdy3;
    assign ctl.s4_load = v3_reg && rdy4;

    assign in_ready  = rdy1;
    assign out_valid = v4_reg;

    // valid bits
    always_comb
    begin
        v1_next = ctl.s1_load || (v1_reg && !rdy2);
        v2_next = ctl.s2_load || (v2_reg && !rdy3);
        v3_next = ctl.s3_load || (v3_reg && !rdy4);
        v4_next = ctl.s4_load || (v4_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // input stalls only when every stage holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty stage");

    // a beat entering the last stage shows up as a result
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.s4_load |=> out_valid)
        else $error("result lost after last stage load");

    // a stage is never loaded while its beat is stuck
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.s3_load && v3_reg) |-> rdy4)
        else $error("stage 3 overwritten");

    // an accepted beat occupies stage 1 next cycle
    a_accept_v1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted beat missing from stage 1");

endmodule

// ----- rtl/core/dipmd_wheel.sv -----
// One wheel lane of the dual incremental PI motor drive: error, PI increment,
// saturating accumulator, truncation and clamp. Depends on dipmd_pkg.
module dipmd_wheel
    import dipmd_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pipe_ctl_t                 ctl,
    input  logic signed [SPEED_W-1:0] speed,
    input  logic signed [SPEED_W-1:0] goal,
    input  logic [GAIN_W-1:0]         prop_gain,
    input  logic [GAIN_W-1:0]         integral_gain,
    input  logic [LIMIT_W-1:0]        drive_limit,
    output logic [LIMIT_W-1:0]        duty,
    output logic                      reverse
);

    localparam int SUM_W = ((ACCUM_BITS > INC_W) ? ACCUM_BITS : INC_W) + 1;
    localparam int QW    = ACCUM_BITS - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] AMAX =
        {{(SUM_W-ACCUM_BITS+1){1'b0}}, {(ACCUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] AMIN = ~AMAX;

    // stage 1: error (also the previous error for the next beat) and change
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;

    assign err_next  = {speed[SPEED_W-1], speed} - {goal[SPEED_W-1], goal};
    assign diff_next = {err_next[ERR_W-1], err_next} - {err_reg[ERR_W-1], err_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= '0;
        else if (ctl.s1_load)
            err_reg <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
            diff_reg <= diff_next;
    end

    // stage 2: kp * change + ki * error, exact in Q.8
    logic signed [GAIN_W:0]     pg_s, ig_s;
    logic signed [PROD_P_W-1:0] p_prod;
    logic signed [PROD_I_W-1:0] i_prod;
    logic signed [INC_W-1:0]    inc_reg, inc_next;

    assign pg_s     = {1'b0, prop_gain};
    assign ig_s     = {1'b0, integral_gain};
    assign p_prod   = pg_s * diff_reg;
    assign i_prod   = ig_s * err_reg;
    assign inc_next = p_prod + {{(INC_W-PROD_I_W){i_prod[PROD_I_W-1]}}, i_prod};

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
            inc_reg <= inc_next;
    end

    // stage 3: saturating accumulate
    logic signed [ACCUM_BITS-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0]      sum;

    assign sum = {{(SUM_W-ACCUM_BITS){acc_reg[ACCUM_BITS-1]}}, acc_reg}
               + {{(SUM_W-INC_W){inc_reg[INC_W-1]}}, inc_reg};

    always_comb
    begin
        if (sum > AMAX)
            acc_next = AMAX[ACCUM_BITS-1:0];
        else if (sum < AMIN)
            acc_next = AMIN[ACCUM_BITS-1:0];
        else
            acc_next = sum[ACCUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.s3_load)
            acc_reg <= acc_next;
    end

    // stage 4: integer part toward zero, clamp, sign and magnitude
    logic signed [QW-1:0]  q;
    logic                  round_up;
    logic                  q_neg;
    logic [QW-1:0]         q_mag;
    logic [QW-1:0]         lim_ext;
    logic [LIMIT_W-1:0]    duty_reg, duty_next;
    logic                  reverse_reg, reverse_next;

    assign round_up = acc_reg[ACCUM_BITS-1] && (|acc_reg[FRAC_BITS-1:0]);
    assign q        = acc_reg[ACCUM_BITS-1:FRAC_BITS] + {{(QW-1){1'b0}}, round_up};
    assign q_neg    = q[QW-1];
    assign q_mag    = q_neg ? (~q + 1'b1) : q;
    assign lim_ext  = {{(QW-LIMIT_W){1'b0}}, drive_limit};

    always_comb
    begin
        if (q_mag > lim_ext)
            duty_next = drive_limit;
        else
            duty_next = q_mag[LIMIT_W-1:0];
        // clamped value is zero, hence forward, when the limit is zero
        reverse_next = q_neg && (duty_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s4_load)
        begin
            duty_reg    <= duty_next;
            reverse_reg <= reverse_next;
        end
    end

    assign duty    = duty_reg;
    assign reverse = reverse_reg;

endmodule

// ----- rtl/core/dual_incremental_pi_motor_drive.sv -----
// An accepted beat passes the error, increment, accumulator and drive value registers before its result is valid.
// Throughput: one beat per cycle while out_ready holds; the accumulator path is one stage.
// Each lane: error, PI increment (two multipliers), saturating add, clamp.
// Reset: accumulators and previous errors clear, gains load 30.0 and 10.0,
// drive limit loads 7100, pipeline empties. No clearing pass.
module dual_incremental_pi_motor_drive
    import dipmd_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SPEED_W-1:0]   left_speed,
    input  logic signed [SPEED_W-1:0]   left_goal,
    input  logic signed [SPEED_W-1:0]   right_speed,
    input  logic signed [SPEED_W-1:0]   right_goal,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LIMIT_W-1:0]          left_duty,
    output logic                        left_pin_a,
    output logic                        left_pin_b,
    output logic [LIMIT_W-1:0]          right_duty,
    output logic                        right_pin_a,
    output logic                        right_pin_b,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integral_gain_reg;
    logic [LIMIT_W-1:0] drive_limit_reg;
    pipe_ctl_t          ctl;
    logic               left_rev, right_rev;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            drive_limit_reg   <= DRIVE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // flow control
    dipmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    // wheel lanes
    dipmd_wheel #(.ACCUM_BITS(ACCUM_BITS)) u_left (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .speed         (left_speed),
        .goal          (left_goal),
        .prop_gain     (prop_gain_reg),
        .integral_gain (integral_gain_reg),
        .drive_limit   (drive_limit_reg),
        .duty          (left_duty),
        .reverse       (left_rev)
    );

    dipmd_wheel #(.ACCUM_BITS(ACCUM_BITS)) u_right (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .speed         (right_speed),
        .goal          (right_goal),
        .prop_gain     (prop_gain_reg),
        .integral_gain (integral_gain_reg),
        .drive_limit   (drive_limit_reg),
        .duty          (right_duty),
        .reverse       (right_rev)
    );

    // direction pins: left reverse is 0,1; right reverse is 1,0
    assign left_pin_a  = !left_rev;
    assign left_pin_b  = left_rev;
    assign right_pin_a = right_rev;
    assign right_pin_b = !right_rev;

endmodule

// ----- test/dual_incremental_pi_motor_drive_test.sv -----
// Self-checking testbench for the dual incremental PI motor drive.
// Predicts each drive command from its own PI accumulator model and compares every result beat.
// Depends on dipmd_pkg and dual_incremental_pi_motor_drive.
module dual_incremental_pi_motor_drive_test;
    import dipmd_pkg::*;

    localparam int ACC_W          = ACCUM_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 200;
    localparam int PRINT_CAP      = 40;
    // register index past the end of the list, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SPEED_W-1:0] l_speed;
        logic signed [SPEED_W-1:0] l_goal;
        logic signed [SPEED_W-1:0] r_speed;
        logic signed [SPEED_W-1:0] r_goal;
    } wheel_tick_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] l_duty;
        logic               l_a;
        logic               l_b;
        logic [LIMIT_W-1:0] r_duty;
        logic               r_a;
        logic               r_b;
    } drive_cmd_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] left_goal;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] right_goal;
    logic                      out_valid;
    logic                      out_ready;
    logic [LIMIT_W-1:0]        left_duty;
    logic                      left_pin_a;
    logic                      left_pin_b;
    logic [LIMIT_W-1:0]        right_duty;
    logic                      right_pin_a;
    logic                      right_pin_b;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // predictor copy of the registers and lane state
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [LIMIT_W-1:0] duty_cap;
    longint             left_acc;
    longint             left_err;
    longint             right_acc;
    longint             right_err;

    drive_cmd_t pending_drive[$];

    int fail_count;
    int ticks_sent;
    int results_seen;
    int reg_writes;
    int quiet_cycles;
    int stall_left;
    int hold_request;
    int long_holds;
    bit idle_on;
    int left_target;
    int right_target;
    int drift_spread;

    dual_incremental_pi_motor_drive #(
        .ACCUM_BITS (ACC_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .left_speed  (left_speed),
        .left_goal   (left_goal),
        .right_speed (right_speed),
        .right_goal  (right_goal),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_duty   (left_duty),
        .left_pin_a  (left_pin_a),
        .left_pin_b  (left_pin_b),
        .right_duty  (right_duty),
        .right_pin_a (right_pin_a),
        .right_pin_b (right_pin_b),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one lane: incremental PI into a saturating Q.8 accumulator, then clamp
    function automatic longint pi_wheel_step(input logic signed [SPEED_W-1:0] speed,
                                             input logic signed [SPEED_W-1:0] goal,
                                             inout longint acc, inout longint prev);
        longint amax;
        longint amin;
        longint err;
        longint total;
        longint lim;
        longint drv;
        amax = (longint'(1) << (ACC_W - 1)) - 1;
        amin = -amax - 1;
        err = longint'(speed) - longint'(goal);
        total = acc + longint'(kp_gain) * (err - prev) + longint'(ki_gain) * err;
        if (total > amax)
            total = amax;
        else if (total < amin)
            total = amin;
        acc = total;
        prev = err;
        // division truncates toward zero, so (-1,0) lands on 0
        drv = total / 256;
        lim = longint'(duty_cap);
        if (drv > lim)
            drv = lim;
        else if (drv < -lim)
            drv = -lim;
        return drv;
    endfunction

    // expected drive command for one tick; advances both lanes
    function automatic drive_cmd_t predict_drive(input wheel_tick_t t);
        drive_cmd_t d;
        longint lv;
        longint rv;
        longint lmag;
        longint rmag;
        lv = pi_wheel_step(t.l_speed, t.l_goal, left_acc, left_err);
        rv = pi_wheel_step(t.r_speed, t.r_goal, right_acc, right_err);
        lmag = (lv < 0) ? -lv : lv;
        rmag = (rv < 0) ? -rv : rv;
        d.l_duty = lmag[LIMIT_W-1:0];
        d.l_a    = (lv < 0) ? 1'b0 : 1'b1;
        d.l_b    = (lv < 0) ? 1'b1 : 1'b0;
        d.r_duty = rmag[LIMIT_W-1:0];
        d.r_a    = (rv < 0) ? 1'b1 : 1'b0;
        d.r_b    = (rv < 0) ? 1'b0 : 1'b1;
        return d;
    endfunction

    function automatic wheel_tick_t tick_of(input int ls, input int lg, input int rs, input int rg);
        wheel_tick_t t;
        t.l_speed = ls[SPEED_W-1:0];
        t.l_goal  = lg[SPEED_W-1:0];
        t.r_speed = rs[SPEED_W-1:0];
        t.r_goal  = rg[SPEED_W-1:0];
        return t;
    endfunction

    // measured speed scattered around a target, kept inside the field range
    function automatic logic signed [SPEED_W-1:0] near_speed(input int target, input int spread);
        int v;
        v = target + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] extreme_speed();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'shFFFF;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // mostly tracking ticks around slowly moving targets, plus noise and extremes
    function automatic wheel_tick_t random_tick();
        wheel_tick_t t;
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            left_target = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 19) == 0)
            right_target = int'($urandom_range(0, 65535)) - 32768;
        if (pick < 60)
        begin
            t.l_goal  = left_target[SPEED_W-1:0];
            t.l_speed = near_speed(left_target, drift_spread);
            t.r_goal  = right_target[SPEED_W-1:0];
            t.r_speed = near_speed(right_target, drift_spread);
        end
        else if (pick < 88)
            t = wheel_tick_t'({$urandom(), $urandom()});
        else
        begin
            t.l_speed = extreme_speed();
            t.l_goal  = extreme_speed();
            t.r_speed = extreme_speed();
            t.r_goal  = extreme_speed();
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // one input beat, with an optional idle burst ahead of it
    task automatic send_tick(input wheel_tick_t t);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        left_speed  <= t.l_speed;
        left_goal   <= t.l_goal;
        right_speed <= t.r_speed;
        right_goal  <= t.r_goal;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_drive.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the pipeline empty
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PROP_GAIN:     kp_gain = val;
            REG_INTEGRAL_GAIN: ki_gain = val;
            REG_DRIVE_LIMIT:   duty_cap = val[LIMIT_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_all_regs(input int kp, input int ki, input int cap);
        set_reg(REG_PROP_GAIN, kp[CFG_DATA_W-1:0]);
        set_reg(REG_INTEGRAL_GAIN, ki[CFG_DATA_W-1:0]);
        set_reg(REG_DRIVE_LIMIT, cap[CFG_DATA_W-1:0]);
    endtask

    // accumulator just below zero truncates to 0 and reads as forward
    task automatic test_fractional_reverse();
        set_all_regs(0, 1, 32767);
        send_tick(tick_of(0, 1, 0, 1));
        send_tick(tick_of(-255, 0, -255, 0));
        send_tick(tick_of(0, 0, 0, 0));
        send_tick(tick_of(1, 0, 1, 0));
    endtask

    task automatic test_field_extremes();
        set_all_regs(PROP_GAIN_RST, INTEGRAL_GAIN_RST, DRIVE_LIMIT_RST);
        send_tick(tick_of(32767, -32768, -32768, 32767));
        send_tick(tick_of(-32768, 32767, 32767, -32768));
        send_tick(tick_of(0, 0, 0, 0));
        send_tick(tick_of(-1, 0, 1, 0));
        send_tick(tick_of(32767, 32767, -32768, -32768));
        send_tick(tick_of(-32768, -1, 32767, 1));
    endtask

    // full gains drive both accumulators into their bounds each way
    task automatic test_accum_saturation();
        set_all_regs(65535, 65535, 32767);
        repeat (4) send_tick(tick_of(32767, -32768, -32768, 32767));
        repeat (4) send_tick(tick_of(-32768, 32767, 32767, -32768));
    endtask

    // limit write with bit 15 set keeps only 15 bits, giving a zero limit;
    // the spare index must not disturb anything
    task automatic test_zero_limit_and_spare_writes();
        set_all_regs(PROP_GAIN_RST, INTEGRAL_GAIN_RST, 16'h8000);
        set_reg(REG_SPARE, 16'hFFFF);
        send_tick(tick_of(32767, -32768, -32768, 32767));
        send_tick(tick_of(-32768, 32767, 32767, -32768));
        send_tick(tick_of(5, 0, -5, 0));
        send_tick(tick_of(0, 0, 0, 0));
    endtask

    task automatic test_random_settings();
        int kp;
        int ki;
        int cap;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin kp = 65535; ki = 65535; cap = 32767; end
                1: begin kp = 0; ki = 0; cap = 0; end
                2: begin kp = 1; ki = 65535; cap = 1; end
                default:
                begin
                    kp  = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 65535);
                    ki  = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 65535);
                    cap = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 32767);
                end
            endcase
            set_all_regs(kp, ki, cap);
            case ($urandom_range(0, 2))
                0: drift_spread = 2;
                1: drift_spread = 60;
                default: drift_spread = 3000;
            endcase
            idle_on = (p % 3 != 2);
            repeat (160) send_tick(random_tick());
        end
        idle_on = 1'b1;
    endtask

    // pause until empty, then stall the output long enough to back up the input
    task automatic test_backpressure();
        set_all_regs($urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(100, 32767));
        drift_spread = 60;
        repeat (30) send_tick(random_tick());
        wait_drained();
        hold_request = LONG_HOLD;
        repeat (60) send_tick(random_tick());
    endtask

    // closing stretch at full rate on both sides
    task automatic test_streaming();
        set_all_regs($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 32767));
        idle_on = 1'b0;
        drift_spread = 500;
        repeat (100) send_tick(random_tick());
    endtask

    // predictor: one expectation per accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_drive.push_back(predict_drive(
                wheel_tick_t'({left_speed, left_goal, right_speed, right_goal})));
    end

    // result beats against the oldest expectation
    always @(posedge clk)
    begin : check_drive
        drive_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drive.size() == 0)
                report_mismatch("beat with nothing expected", 0, 0);
            else
            begin
                want = pending_drive.pop_front();
                check_field("left_duty", left_duty, want.l_duty);
                check_field("left_pin_a", left_pin_a, want.l_a);
                check_field("left_pin_b", left_pin_b, want.l_b);
                check_field("right_duty", right_duty, want.r_duty);
                check_field("right_pin_a", right_pin_a, want.r_a);
                check_field("right_pin_b", right_pin_b, want.r_b);
            end
            results_seen++;
        end
    end

    // output side: random stall bursts, plus a long hold on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request > 0)
            begin
                stall_left = hold_request - 1;
                hold_request = 0;
                long_holds++;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < 20)
            begin
                stall_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_drive.size());
            $display("dual_incremental_pi_motor_drive test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        left_speed   <= '0;
        left_goal    <= '0;
        right_speed  <= '0;
        right_goal   <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        kp_gain      = PROP_GAIN_RST;
        ki_gain      = INTEGRAL_GAIN_RST;
        duty_cap     = DRIVE_LIMIT_RST;
        left_acc     = 0;
        left_err     = 0;
        right_acc    = 0;
        right_err    = 0;
        fail_count   = 0;
        ticks_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        hold_request = 0;
        long_holds   = 0;
        idle_on      = 1'b1;
        left_target  = 0;
        right_target = 0;
        drift_spread = 60;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fractional_reverse();
        test_field_extremes();
        test_accum_saturation();
        test_zero_limit_and_spare_writes();
        test_random_settings();
        test_backpressure();
        test_streaming();

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks and %0d drive results over %0d register writes,",
                 ticks_sent, results_seen, reg_writes);
        $display("incl. saturation, fractional reverse, zero limit and %0d long output stall(s).",
                 long_holds);
        if (fail_count == 0)
            $display("dual_incremental_pi_motor_drive test passed");
        else
            $display("dual_incremental_pi_motor_drive test failed");
        $finish;
    end

endmodule
